/* hw/rtl/mrchp_pkg.sv */
// ============================================================================
// mrchp_pkg: shared definitions for the multichannel RC high-pass filter
// Default sizes, register indexes and configuration port widths.
// ============================================================================
package mrchp_pkg;

    // Default sizes handed to the top level as parameter defaults.
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int ALPHA_BITS_DEF   = 16;

    // The alpha reset value is given for a 16-bit fraction and scaled to the
    // configured coefficient width at elaboration.
    localparam int ALPHA_RESET     = 64880;
    localparam int ALPHA_REF_BITS  = 16;

    // Configuration port.
    localparam int CFG_INDEX_W     = 4;
    localparam int CFG_DATA_W      = 32;
    localparam int CHAN_COUNT_W    = 4;
    localparam int CHAN_COUNT_INIT = 1;

    // Depth of the queue between the front and back ends (a power of two).
    localparam int QUEUE_DEPTH     = 2;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ALPHA         = 4'd0,
        REG_CHANNEL_COUNT = 4'd1
    } reg_index_t;

endpackage

/* hw/rtl/mrchp_front.sv */
// ============================================================================
// mrchp_front: channel assignment and input differencing
// Assigns each request to a channel, forms x - last_input for that channel
// and tags it with the channel's primed flag for the back end.
// ============================================================================
module mrchp_front #(
    parameter int MAX_CHANNELS = mrchp_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = mrchp_pkg::SAMPLE_BITS_DEF,
    parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [mrchp_pkg::CHAN_COUNT_W-1:0]   channel_count,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [SAMPLE_BITS-1:0]        in_sample,
    output logic                                 q_push,
    input  logic                                 q_full,
    output logic                                 q_primed,
    output logic [CH_W-1:0]                      q_channel,
    output logic signed [SAMPLE_BITS:0]          q_diff
);

    localparam int CNT_W = CH_W + 1;

    logic [CH_W-1:0]              pos_reg, pos_next;
    logic [MAX_CHANNELS-1:0]      primed_reg;
    logic signed [SAMPLE_BITS-1:0] last_in_reg [MAX_CHANNELS];

    logic [CNT_W-1:0] active;
    logic [CH_W-1:0]  ch;
    logic [CNT_W-1:0] ch_inc;
    logic             accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Clamp the channel count into 1..MAX_CHANNELS.
    always_comb begin
        if (channel_count == '0) begin
            active = CNT_W'(1);
        end else if (int'(channel_count) > MAX_CHANNELS) begin
            active = CNT_W'(MAX_CHANNELS);
        end else begin
            active = CNT_W'(channel_count);
        end
    end

    // A counter left beyond a reduced count restarts at channel 0.
    always_comb begin
        ch       = ({1'b0, pos_reg} < active) ? pos_reg : '0;
        ch_inc   = {1'b0, ch} + CNT_W'(1);
        pos_next = (ch_inc >= active) ? '0 : ch_inc[CH_W-1:0];
    end

    // Channel counter and primed flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            primed_reg <= '0;
        end else if (accept) begin
            pos_reg        <= pos_next;
            primed_reg[ch] <= 1'b1;
        end
    end

    // Last input per channel; read only once the channel is primed.
    always_ff @(posedge aclk) begin
        if (accept) begin
            last_in_reg[ch] <= in_sample;
        end
    end

    // Entry for the back end.
    assign q_push    = accept;
    assign q_primed  = primed_reg[ch];
    assign q_channel = ch;
    assign q_diff    = {in_sample[SAMPLE_BITS-1], in_sample}
                     - {last_in_reg[ch][SAMPLE_BITS-1], last_in_reg[ch]};

endmodule

/* hw/rtl/mrchp_queue.sv */
// ============================================================================
// mrchp_queue: short first-in first-out queue
// Decouples the front end from the back end so that each can stall alone.
// ============================================================================
module mrchp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mrchp_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Pointers and fill count; the depth is a power of two so pointers wrap.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/mrchp_back.sv */
// ============================================================================
// mrchp_back: filter recurrence and output register
// Computes round(alpha * (last_output + diff)), saturates it, updates the
// channel's last output and holds the result for the output channel.
// ============================================================================
module mrchp_back #(
    parameter int MAX_CHANNELS = mrchp_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = mrchp_pkg::SAMPLE_BITS_DEF,
    parameter int ALPHA_BITS   = mrchp_pkg::ALPHA_BITS_DEF,
    parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ALPHA_BITS-1:0]         alpha,
    input  logic                          q_not_empty,
    output logic                          q_pop,
    input  logic                          q_primed,
    input  logic [CH_W-1:0]               q_channel,
    input  logic signed [SAMPLE_BITS:0]   q_diff,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_filtered_sample,
    output logic [CH_W-1:0]               out_channel,
    output logic                          out_saturated
);

    localparam int D_W    = SAMPLE_BITS + 2;
    localparam int PROD_W = SAMPLE_BITS + ALPHA_BITS + 3;
    localparam int R_W    = PROD_W - ALPHA_BITS;
    localparam logic signed [R_W-1:0] SMAX =
        R_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [R_W-1:0] SMIN = -SMAX - R_W'(1);
    localparam logic [PROD_W-1:0] HALF = PROD_W'(64'd1 << (ALPHA_BITS - 1));

    logic signed [SAMPLE_BITS-1:0] last_out_reg [MAX_CHANNELS];
    logic                          valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [CH_W-1:0]               channel_reg;
    logic                          sat_reg;

    logic signed [D_W-1:0]         d;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      rnd;
    logic signed [R_W-1:0]         r;
    logic signed [SAMPLE_BITS-1:0] y;
    logic                          sat;
    logic signed [SAMPLE_BITS-1:0] lo;

    // Take the next entry whenever the output register is free or draining.
    assign q_pop = q_not_empty && (!valid_reg || out_ready);

    // Multiply, round to nearest with ties up, then floor by the shift.
    always_comb begin
        lo   = last_out_reg[q_channel];
        d    = {{2{lo[SAMPLE_BITS-1]}}, lo} + {q_diff[SAMPLE_BITS], q_diff};
        prod = $signed(d) * $signed({1'b0, alpha});
        rnd  = prod + $signed(HALF);
        r    = rnd[PROD_W-1:ALPHA_BITS];
    end

    // Saturate; an unprimed channel gives zero.
    always_comb begin
        y   = '0;
        sat = 1'b0;
        if (q_primed) begin
            if (r > SMAX) begin
                y   = SMAX[SAMPLE_BITS-1:0];
                sat = 1'b1;
            end else if (r < SMIN) begin
                y   = SMIN[SAMPLE_BITS-1:0];
                sat = 1'b1;
            end else begin
                y = r[SAMPLE_BITS-1:0];
            end
        end
    end

    // Per-channel last output; read only once the channel is primed.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            last_out_reg[q_channel] <= y;
        end
    end

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            sample_reg  <= y;
            channel_reg <= q_channel;
            sat_reg     <= sat;
        end
    end

    assign out_valid           = valid_reg;
    assign out_filtered_sample = sample_reg;
    assign out_channel         = channel_reg;
    assign out_saturated       = sat_reg;

endmodule

/* hw/rtl/multichannel_rc_high_pass.sv */
// ============================================================================
// multichannel_rc_high_pass: interleaved multichannel first-order high-pass
// Front end assigns channels and differences inputs, a two-entry queue
// decouples it from the back end that runs the output recurrence.
// ============================================================================
// An accepted request is written into the queue, then into the back end's output
// register, which drives m_valid. Throughput: one request per cycle while m_ready
// stays high; last_output takes one multiply, round and saturate per request.
// Reset: clears the channel counter, primed flags, queue and output valid,
// and restores alpha and channel_count; filter history needs no clearing.
module multichannel_rc_high_pass #(
    parameter int MAX_CHANNELS = mrchp_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = mrchp_pkg::SAMPLE_BITS_DEF,
    parameter int ALPHA_BITS   = mrchp_pkg::ALPHA_BITS_DEF,
    parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [SAMPLE_BITS-1:0]       m_filtered_sample,
    output logic [CH_W-1:0]                     m_channel,
    output logic                                m_saturated,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mrchp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mrchp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int Q_W = 1 + CH_W + SAMPLE_BITS + 1;
    localparam logic [ALPHA_BITS-1:0] ALPHA_INIT =
        (ALPHA_BITS >= mrchp_pkg::ALPHA_REF_BITS)
        ? ALPHA_BITS'(mrchp_pkg::ALPHA_RESET << (ALPHA_BITS - mrchp_pkg::ALPHA_REF_BITS))
        : ALPHA_BITS'(mrchp_pkg::ALPHA_RESET >> (mrchp_pkg::ALPHA_REF_BITS - ALPHA_BITS));

    logic [ALPHA_BITS-1:0]              alpha_reg;
    logic [mrchp_pkg::CHAN_COUNT_W-1:0] chan_count_reg;

    logic                          q_push, q_full, q_pop, q_not_empty;
    logic                          f_primed;
    logic [CH_W-1:0]               f_channel;
    logic signed [SAMPLE_BITS:0]   f_diff;
    logic [Q_W-1:0]                q_in, q_out;
    logic                          b_primed;
    logic [CH_W-1:0]               b_channel;
    logic signed [SAMPLE_BITS:0]   b_diff;

    // Configuration registers; unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg      <= ALPHA_INIT;
            chan_count_reg <= mrchp_pkg::CHAN_COUNT_W'(mrchp_pkg::CHAN_COUNT_INIT);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mrchp_pkg::REG_ALPHA: begin
                    alpha_reg <= cfg_data[ALPHA_BITS-1:0];
                end
                mrchp_pkg::REG_CHANNEL_COUNT: begin
                    chan_count_reg <= cfg_data[mrchp_pkg::CHAN_COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Front end.
    mrchp_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .CH_W         (CH_W)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .channel_count (chan_count_reg),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_sample     (s_sample),
        .q_push        (q_push),
        .q_full        (q_full),
        .q_primed      (f_primed),
        .q_channel     (f_channel),
        .q_diff        (f_diff)
    );

    // Queue between the two ends.
    assign q_in = {f_primed, f_channel, f_diff};

    mrchp_queue #(
        .WIDTH (Q_W),
        .DEPTH (mrchp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    assign b_primed  = q_out[Q_W-1];
    assign b_channel = q_out[Q_W-2 -: CH_W];
    assign b_diff    = q_out[SAMPLE_BITS:0];

    // Back end.
    mrchp_back #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .ALPHA_BITS   (ALPHA_BITS),
        .CH_W         (CH_W)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .alpha               (alpha_reg),
        .q_not_empty         (q_not_empty),
        .q_pop               (q_pop),
        .q_primed            (b_primed),
        .q_channel           (b_channel),
        .q_diff              (b_diff),
        .out_valid           (m_valid),
        .out_ready           (m_ready),
        .out_filtered_sample (m_filtered_sample),
        .out_channel         (m_channel),
        .out_saturated       (m_saturated)
    );

    // A clipped result sits exactly on one of the rails.
    a_sat_on_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
        ((m_filtered_sample == {1'b0, {(SAMPLE_BITS-1){1'b1}}}) ||
         (m_filtered_sample == {1'b1, {(SAMPLE_BITS-1){1'b0}}})))
        else $error("saturated result is not at a rail");

    // Results only name channels that exist.
    a_channel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_channel) < MAX_CHANNELS))
        else $error("result channel out of range");

    // Requests are only taken while the queue has room.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("queue written while full");

    // An entry pending in the queue with a free output is always drained.
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_not_empty && !m_valid) |=> m_valid)
        else $error("back end did not take a pending entry");

endmodule
